[sv/udfes_pkg.sv]
// Shared types and constants for the UART dual FIFO and error statistics block.
// Depends on nothing; every other file imports it.
package udfes_pkg;

  // Default ring depth in bytes.
  localparam int unsigned FifoDepthDefault = 64;

  // Width of each statistics counter.
  localparam int unsigned CntW = 16;

  // Counter slots.
  localparam int unsigned CntNum      = 6;
  localparam int unsigned CNT_HW       = 0;
  localparam int unsigned CNT_FRAMING  = 1;
  localparam int unsigned CNT_OVERFLOW = 2;
  localparam int unsigned CNT_PARITY   = 3;
  localparam int unsigned CNT_RX       = 4;
  localparam int unsigned CNT_TX       = 5;

  // Command codes carried on the input channel.
  typedef enum logic [2:0] {
    CMD_RX_BYTE = 3'd0,
    CMD_TX_PUSH = 3'd1,
    CMD_RX_POP  = 3'd2,
    CMD_TX_TICK = 3'd3,
    CMD_CLEAR   = 3'd4
  } cmd_e;

  // Sticky error codes.
  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_FRAMING  = 2'd1,
    ERR_OVERFLOW = 2'd2,
    ERR_PARITY   = 2'd3
  } err_e;

  // Which ring supplies the outgoing byte.
  typedef enum logic [1:0] {
    SEL_NONE = 2'd0,
    SEL_RX   = 2'd1,
    SEL_TX   = 2'd2
  } sel_e;

  // Control from the top level to a ring.
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } ring_ctrl_t;

  // Status from a ring to the top level.
  typedef struct packed {
    logic empty;
    logic full;
  } ring_stat_t;

  // One result word as held in the output register.
  typedef struct packed {
    logic            accepted;
    logic [7:0]      byte_out;
    err_e            last_error_code;
    logic            rx_ready;
    logic            tx_ready;
    logic            tx_irq_enable;
    logic [CntW-1:0] hw_error_total;
    logic [CntW-1:0] framing_total;
    logic [CntW-1:0] overflow_total;
    logic [CntW-1:0] parity_total;
    logic [CntW-1:0] rx_total;
    logic [CntW-1:0] tx_total;
  } res_t;

endpackage

[sv/udfes_if.sv]
// Valid/ready channel interfaces for the command input and the result output.
// Depends on udfes_pkg.
interface udfes_in_if;
  import udfes_pkg::*;

  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [7:0] byte_in;
  logic       framing_flag;
  logic       overrun_flag;
  logic       parity_flag;

  modport source (
    output valid, cmd, byte_in, framing_flag, overrun_flag, parity_flag,
    input  ready
  );
  modport sink (
    input  valid, cmd, byte_in, framing_flag, overrun_flag, parity_flag,
    output ready
  );
endinterface

interface udfes_out_if;
  import udfes_pkg::*;

  logic            valid;
  logic            ready;
  logic            accepted;
  logic [7:0]      byte_out;
  logic [1:0]      last_error_code;
  logic            rx_ready;
  logic            tx_ready;
  logic            tx_irq_enable;
  logic [CntW-1:0] hw_error_total;
  logic [CntW-1:0] framing_total;
  logic [CntW-1:0] overflow_total;
  logic [CntW-1:0] parity_total;
  logic [CntW-1:0] rx_total;
  logic [CntW-1:0] tx_total;

  modport source (
    output valid, accepted, byte_out, last_error_code, rx_ready, tx_ready,
           tx_irq_enable, hw_error_total, framing_total, overflow_total,
           parity_total, rx_total, tx_total,
    input  ready
  );
  modport sink (
    input  valid, accepted, byte_out, last_error_code, rx_ready, tx_ready,
           tx_irq_enable, hw_error_total, framing_total, overflow_total,
           parity_total, rx_total, tx_total,
    output ready
  );
endinterface

[sv/udfes_ring.sv]
// Byte ring FIFO: a synchronous memory with registered read, plus pointers and level.
// Depends on udfes_pkg.
module udfes_ring #(
  parameter int unsigned Depth = udfes_pkg::FifoDepthDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  udfes_pkg::ring_ctrl_t  ctrl_i,
  input  logic [7:0]             wdata_i,
  output logic [7:0]             rdata_o,
  output udfes_pkg::ring_stat_t  stat_o
);
  import udfes_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned LvlW = $clog2(Depth + 1);

  logic [7:0]      mem_q [Depth];
  logic [7:0]      rdata_q;
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [LvlW-1:0] level_q, level_d;

  // Pointer and level update; clear wins over everything else.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    level_d  = level_q;
    if (ctrl_i.clear) begin
      wr_ptr_d = '0;
      rd_ptr_d = '0;
      level_d  = '0;
    end else begin
      if (ctrl_i.push) begin
        wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
        level_d  = level_q + 1'b1;
      end
      if (ctrl_i.pop) begin
        rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
        level_d  = level_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  // Storage: write at the write pointer, registered read at the read pointer.
  // The read register holds its value until the next pop.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push && !ctrl_i.clear) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
    if (ctrl_i.pop && !ctrl_i.clear) begin
      rdata_q <= mem_q[rd_ptr_q];
    end
  end

  assign rdata_o      = rdata_q;
  assign stat_o.empty = (level_q == '0);
  assign stat_o.full  = (level_q == LvlW'(Depth));

endmodule

[sv/uart_dual_fifo_with_error_stats.sv]
// Top level of the UART dual FIFO and error statistics block.
// Depends on udfes_pkg, udfes_in_if, udfes_out_if and udfes_ring.
//
//   Port    Dir  Moves                                  Handshake
//   in_i    in   command word: cmd, byte, line flags    valid/ready
//   out_o   out  result word: status, byte, counters    valid/ready
//
// A command word is taken into the pending register, in the same cycle as the
// ring memory read; its result then moves on into the output register once that is free. A new word
// can be taken every cycle as long as the output register drains, so the
// sustained rate is one word per cycle.
// Reset (or the clear command) empties both rings and zeroes all counters;
// the ring memories themselves are not cleared. A stalled output holds one
// result plus one pending word, then input ready drops.
module uart_dual_fifo_with_error_stats #(
  parameter int unsigned FifoDepth = udfes_pkg::FifoDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  udfes_in_if.sink           in_i,
  udfes_out_if.source        out_o
);
  import udfes_pkg::*;

  ring_ctrl_t rx_ctrl, tx_ctrl;
  ring_stat_t rx_stat, tx_stat;
  logic [7:0] rx_rdata, tx_rdata;

  logic            in_fire;
  logic            pend_go;
  logic            pend_q;
  logic            pend_acc_q, pend_acc_d;
  sel_e            pend_sel_q, pend_sel_d;
  err_e            last_err_q, last_err_d;
  logic            irq_q, irq_d;
  logic [CntW-1:0] cnt_q [CntNum];
  logic [CntW-1:0] cnt_d [CntNum];
  logic            out_valid_q;
  res_t            res_q, res_d;

  // Receive and transmit rings.
  udfes_ring #(.Depth(FifoDepth)) u_rx_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (rx_ctrl),
    .wdata_i (in_i.byte_in),
    .rdata_o (rx_rdata),
    .stat_o  (rx_stat)
  );

  udfes_ring #(.Depth(FifoDepth)) u_tx_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (tx_ctrl),
    .wdata_i (in_i.byte_in),
    .rdata_o (tx_rdata),
    .stat_o  (tx_stat)
  );

  // The pending word moves to the output register when that register is free.
  assign pend_go    = !out_valid_q || out_o.ready;
  assign in_i.ready = !pend_q || pend_go;
  assign in_fire    = in_i.valid && in_i.ready;

  // Command decode: ring control, counters, sticky error and interrupt enable.
  always_comb begin
    rx_ctrl    = '0;
    tx_ctrl    = '0;
    pend_acc_d = 1'b0;
    pend_sel_d = SEL_NONE;
    last_err_d = last_err_q;
    irq_d      = irq_q;
    cnt_d      = cnt_q;
    if (in_fire) begin
      unique case (in_i.cmd)
        CMD_RX_BYTE: begin
          if (in_i.framing_flag || in_i.overrun_flag || in_i.parity_flag) begin
            cnt_d[CNT_HW] = cnt_q[CNT_HW] + 1'b1;
            if (in_i.framing_flag) begin
              cnt_d[CNT_FRAMING] = cnt_q[CNT_FRAMING] + 1'b1;
            end
            if (in_i.overrun_flag) begin
              cnt_d[CNT_OVERFLOW] = cnt_q[CNT_OVERFLOW] + 1'b1;
            end
            if (in_i.parity_flag) begin
              cnt_d[CNT_PARITY] = cnt_q[CNT_PARITY] + 1'b1;
            end
            // Parity outranks overrun, which outranks framing.
            priority if (in_i.parity_flag) begin
              last_err_d = ERR_PARITY;
            end else if (in_i.overrun_flag) begin
              last_err_d = ERR_OVERFLOW;
            end else begin
              last_err_d = ERR_FRAMING;
            end
          end else if (rx_stat.full) begin
            cnt_d[CNT_OVERFLOW] = cnt_q[CNT_OVERFLOW] + 1'b1;
            last_err_d          = ERR_OVERFLOW;
          end else begin
            rx_ctrl.push   = 1'b1;
            cnt_d[CNT_RX]  = cnt_q[CNT_RX] + 1'b1;
            pend_acc_d     = 1'b1;
          end
        end
        CMD_TX_PUSH: begin
          if (!tx_stat.full) begin
            tx_ctrl.push = 1'b1;
            irq_d        = 1'b1;
            pend_acc_d   = 1'b1;
          end
        end
        CMD_RX_POP: begin
          if (!rx_stat.empty) begin
            rx_ctrl.pop = 1'b1;
            pend_sel_d  = SEL_RX;
            pend_acc_d  = 1'b1;
          end
        end
        CMD_TX_TICK: begin
          if (!tx_stat.empty) begin
            tx_ctrl.pop   = 1'b1;
            cnt_d[CNT_TX] = cnt_q[CNT_TX] + 1'b1;
            pend_sel_d    = SEL_TX;
            pend_acc_d    = 1'b1;
          end else begin
            irq_d = 1'b0;
          end
        end
        CMD_CLEAR: begin
          rx_ctrl.clear = 1'b1;
          tx_ctrl.clear = 1'b1;
          last_err_d    = ERR_NONE;
          irq_d         = 1'b0;
          for (int i = 0; i < CntNum; i++) begin
            cnt_d[i] = '0;
          end
        end
        default: begin
          // Unused command codes change nothing.
        end
      endcase
    end
  end

  // Block state and the pending word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_err_q <= ERR_NONE;
      irq_q      <= 1'b0;
      pend_q     <= 1'b0;
      pend_acc_q <= 1'b0;
      pend_sel_q <= SEL_NONE;
      for (int i = 0; i < CntNum; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      last_err_q <= last_err_d;
      irq_q      <= irq_d;
      cnt_q      <= cnt_d;
      if (in_fire) begin
        pend_q     <= 1'b1;
        pend_acc_q <= pend_acc_d;
        pend_sel_q <= pend_sel_d;
      end else if (pend_go) begin
        pend_q <= 1'b0;
      end
    end
  end

  // Result word assembled from the state left by the pending command.
  always_comb begin
    res_d.accepted = pend_acc_q;
    unique case (pend_sel_q)
      SEL_RX:  res_d.byte_out = rx_rdata;
      SEL_TX:  res_d.byte_out = tx_rdata;
      default: res_d.byte_out = '0;
    endcase
    res_d.last_error_code = last_err_q;
    res_d.rx_ready        = !rx_stat.empty;
    res_d.tx_ready        = !tx_stat.full;
    res_d.tx_irq_enable   = irq_q;
    res_d.hw_error_total  = cnt_q[CNT_HW];
    res_d.framing_total   = cnt_q[CNT_FRAMING];
    res_d.overflow_total  = cnt_q[CNT_OVERFLOW];
    res_d.parity_total    = cnt_q[CNT_PARITY];
    res_d.rx_total        = cnt_q[CNT_RX];
    res_d.tx_total        = cnt_q[CNT_TX];
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pend_q && pend_go) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_q && pend_go) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.accepted        = res_q.accepted;
  assign out_o.byte_out        = res_q.byte_out;
  assign out_o.last_error_code = res_q.last_error_code;
  assign out_o.rx_ready        = res_q.rx_ready;
  assign out_o.tx_ready        = res_q.tx_ready;
  assign out_o.tx_irq_enable   = res_q.tx_irq_enable;
  assign out_o.hw_error_total  = res_q.hw_error_total;
  assign out_o.framing_total   = res_q.framing_total;
  assign out_o.overflow_total  = res_q.overflow_total;
  assign out_o.parity_total    = res_q.parity_total;
  assign out_o.rx_total        = res_q.rx_total;
  assign out_o.tx_total        = res_q.tx_total;

endmodule

[tb/testbench.sv]
// Self-checking bench for uart_dual_fifo_with_error_stats: drives command words,
// predicts every result word in place and compares it field by field.
// Depends on udfes_pkg, udfes_in_if, udfes_out_if and the block's RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import udfes_pkg::*;

  localparam int unsigned Depth = FifoDepthDefault;
  localparam int unsigned WordTarget = 850;
  localparam int unsigned CalmTail = 80;
  localparam logic [2:0] CmdSpareFirst = 3'd5;
  localparam logic [2:0] CmdSpareLast = 3'd7;

  // One command word as queued for the driver.
  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] data;
    logic       fe;
    logic       ov;
    logic       pe;
    logic       hold;  // wait until every result has come back first
  } uart_word_t;

  logic clk_i;
  logic rst_ni;

  udfes_in_if  in_if ();
  udfes_out_if out_if ();

  uart_dual_fifo_with_error_stats u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  uart_word_t  pending_words[$];
  res_t        expected_results[$];
  uart_word_t  on_wire;
  int unsigned n_issued;
  int unsigned n_checked;
  int unsigned n_words;
  int unsigned calm_from;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned failures;
  bit          drv_show;

  // Shadow copy of the block state.
  logic [7:0]      rx_ring [Depth];
  logic [7:0]      tx_ring [Depth];
  int unsigned     rx_rd, rx_wr, rx_fill;
  int unsigned     tx_rd, tx_wr, tx_fill;
  logic            irq_on;
  err_e            sticky_err;
  logic [CntW-1:0] stats [CntNum];

  // Return the shadow state to its reset values; the rings keep their data.
  function automatic void clear_shadow();
    rx_rd = 0;
    rx_wr = 0;
    rx_fill = 0;
    tx_rd = 0;
    tx_wr = 0;
    tx_fill = 0;
    irq_on = 1'b0;
    sticky_err = ERR_NONE;
    for (int i = 0; i < CntNum; i++) stats[i] = '0;
  endfunction

  // Apply one command word to the shadow state and build its result word.
  function automatic res_t uart_step(uart_word_t w);
    res_t r;
    r = '0;
    case (w.cmd)
      CMD_RX_BYTE: begin
        if (w.fe || w.ov || w.pe) begin
          // Flagged byte: dropped, parity beats overrun beats framing.
          stats[CNT_HW] += 1'b1;
          if (w.fe) begin
            stats[CNT_FRAMING] += 1'b1;
            sticky_err = ERR_FRAMING;
          end
          if (w.ov) begin
            stats[CNT_OVERFLOW] += 1'b1;
            sticky_err = ERR_OVERFLOW;
          end
          if (w.pe) begin
            stats[CNT_PARITY] += 1'b1;
            sticky_err = ERR_PARITY;
          end
        end else if (rx_fill >= Depth) begin
          stats[CNT_OVERFLOW] += 1'b1;
          sticky_err = ERR_OVERFLOW;
        end else begin
          rx_ring[rx_wr] = w.data;
          rx_wr = (rx_wr + 1) % Depth;
          rx_fill++;
          stats[CNT_RX] += 1'b1;
          r.accepted = 1'b1;
        end
      end
      CMD_TX_PUSH: begin
        if (tx_fill < Depth) begin
          tx_ring[tx_wr] = w.data;
          tx_wr = (tx_wr + 1) % Depth;
          tx_fill++;
          irq_on = 1'b1;
          r.accepted = 1'b1;
        end
      end
      CMD_RX_POP: begin
        if (rx_fill > 0) begin
          r.byte_out = rx_ring[rx_rd];
          rx_rd = (rx_rd + 1) % Depth;
          rx_fill--;
          r.accepted = 1'b1;
        end
      end
      CMD_TX_TICK: begin
        if (tx_fill > 0) begin
          r.byte_out = tx_ring[tx_rd];
          tx_rd = (tx_rd + 1) % Depth;
          tx_fill--;
          stats[CNT_TX] += 1'b1;
          r.accepted = 1'b1;
        end else begin
          irq_on = 1'b0;
        end
      end
      CMD_CLEAR: clear_shadow();
      default: ;
    endcase
    r.last_error_code = sticky_err;
    r.rx_ready        = (rx_fill > 0);
    r.tx_ready        = (tx_fill < Depth);
    r.tx_irq_enable   = irq_on;
    r.hw_error_total  = stats[CNT_HW];
    r.framing_total   = stats[CNT_FRAMING];
    r.overflow_total  = stats[CNT_OVERFLOW];
    r.parity_total    = stats[CNT_PARITY];
    r.rx_total        = stats[CNT_RX];
    r.tx_total        = stats[CNT_TX];
    return r;
  endfunction

  task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      failures++;
    end
  endtask

  task automatic add_word(logic [2:0] cmd, logic [7:0] data, logic fe, logic ov, logic pe);
    uart_word_t w;
    w = '{cmd: cmd, data: data, fe: fe, ov: ov, pe: pe, hold: 1'b0};
    pending_words.push_back(w);
    if (cmd <= CMD_CLEAR) n_words++;
  endtask

  // A mixed word: mostly line bytes, pushes, pops and ticks, rarely a clear.
  task automatic add_mixed_word();
    int unsigned pick;
    logic [2:0]  cmd;
    logic [2:0]  flags;
    pick = $urandom_range(0, 99);
    if (pick < 30) cmd = CMD_RX_BYTE;
    else if (pick < 52) cmd = CMD_TX_PUSH;
    else if (pick < 74) cmd = CMD_RX_POP;
    else if (pick < 95) cmd = CMD_TX_TICK;
    else if (pick < 98) cmd = 3'($urandom_range(CmdSpareFirst, CmdSpareLast));
    else cmd = CMD_CLEAR;
    flags = 3'($urandom_range(0, 7));
    if (cmd == CMD_RX_BYTE && $urandom_range(0, 3) != 0) flags = '0;
    add_word(cmd, 8'($urandom), flags[0], flags[1], flags[2]);
  endtask

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Reset and known values on every input of the block.
  initial begin
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.cmd = CMD_RX_BYTE;
    in_if.byte_in = '0;
    in_if.framing_flag = 1'b0;
    in_if.overrun_flag = 1'b0;
    in_if.parity_flag = 1'b0;
    out_if.ready = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Stimulus: directed words first, then random bursts; finally wait for the drain.
  initial begin
    int unsigned burst;
    int unsigned kind;
    int unsigned mid_hold;
    logic [2:0]  flags;
    n_issued = 0;
    n_checked = 0;
    n_words = 0;
    gap_left = 0;
    stall_left = 0;
    failures = 0;
    clear_shadow();

    add_word(CMD_RX_POP, 8'h00, 1'b0, 1'b0, 1'b0);
    add_word(CMD_TX_TICK, 8'h00, 1'b0, 1'b0, 1'b0);
    add_word(CMD_RX_BYTE, 8'h00, 1'b0, 1'b0, 1'b0);
    add_word(CMD_RX_BYTE, 8'hFF, 1'b0, 1'b0, 1'b0);
    add_word(CMD_RX_BYTE, 8'h12, 1'b1, 1'b0, 1'b0);
    add_word(CMD_RX_BYTE, 8'h34, 1'b0, 1'b1, 1'b0);
    add_word(CMD_RX_BYTE, 8'h56, 1'b0, 1'b0, 1'b1);
    add_word(CMD_RX_BYTE, 8'h78, 1'b1, 1'b1, 1'b1);
    add_word(CMD_RX_BYTE, 8'h9A, 1'b1, 1'b1, 1'b0);
    add_word(CMD_RX_POP, 8'hFF, 1'b1, 1'b1, 1'b1);
    add_word(CMD_RX_POP, 8'h00, 1'b0, 1'b0, 1'b0);
    add_word(CMD_RX_POP, 8'h00, 1'b0, 1'b0, 1'b0);
    add_word(CMD_TX_PUSH, 8'hA5, 1'b1, 1'b1, 1'b1);
    add_word(CMD_TX_PUSH, 8'h5A, 1'b0, 1'b0, 1'b0);
    add_word(CMD_TX_TICK, 8'hFF, 1'b0, 1'b0, 1'b0);
    add_word(CMD_TX_TICK, 8'h00, 1'b0, 1'b0, 1'b0);
    add_word(CMD_TX_TICK, 8'h00, 1'b0, 1'b0, 1'b0);
    add_word(CmdSpareFirst, 8'hFF, 1'b1, 1'b1, 1'b1);
    add_word(CmdSpareFirst + 3'd1, 8'h0F, 1'b0, 1'b1, 1'b0);
    add_word(CmdSpareLast, 8'hF0, 1'b1, 1'b0, 1'b1);
    add_word(CMD_RX_BYTE, 8'h3C, 1'b1, 1'b0, 1'b1);
    add_word(CMD_TX_PUSH, 8'h81, 1'b0, 1'b0, 1'b0);
    add_word(CMD_CLEAR, 8'hFF, 1'b1, 1'b1, 1'b1);
    add_word(CMD_RX_POP, 8'h00, 1'b0, 1'b0, 1'b0);
    add_word(CMD_TX_TICK, 8'h00, 1'b0, 1'b0, 1'b0);

    // The first random word waits for the directed results to drain.
    mid_hold = pending_words.size();
    add_mixed_word();
    pending_words[mid_hold].hold = 1'b1;

    // Random bursts: long fills and drains reach the full and empty rings.
    while (n_words < WordTarget) begin
      kind = $urandom_range(0, 9);
      burst = $urandom_range(40, 80);
      case (kind)
        4: repeat (burst) begin
          flags = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(1, 7)) : 3'b000;
          add_word(CMD_RX_BYTE, 8'($urandom), flags[0], flags[1], flags[2]);
        end
        5: repeat (burst) add_word(CMD_RX_POP, 8'($urandom), 1'($urandom), 1'($urandom),
                                   1'($urandom));
        6: repeat (burst) add_word(CMD_TX_PUSH, 8'($urandom), 1'($urandom), 1'($urandom),
                                   1'($urandom));
        7: repeat (burst) add_word(CMD_TX_TICK, 8'($urandom), 1'($urandom), 1'($urandom),
                                   1'($urandom));
        8: repeat ($urandom_range(5, 15)) begin
          flags = 3'($urandom_range(1, 7));
          add_word(CMD_RX_BYTE, 8'($urandom), flags[0], flags[1], flags[2]);
        end
        9: begin
          if ($urandom_range(0, 2) == 0) add_word(CMD_CLEAR, 8'($urandom), 1'b0, 1'b0, 1'b0);
          else add_mixed_word();
        end
        default: repeat ($urandom_range(10, 40)) add_mixed_word();
      endcase
      if (mid_hold < 100 && n_words > WordTarget / 2) begin
        mid_hold = pending_words.size();
        add_mixed_word();
        pending_words[mid_hold].hold = 1'b1;
      end
    end
    calm_from = pending_words.size() - CalmTail;

    wait (rst_ni === 1'b1);
    n_words = pending_words.size();
    do @(posedge clk_i);
    while (!(pending_words.size() == 0 && !in_if.valid && n_checked == n_words));
    repeat (10) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $error("%0d result words never arrived", expected_results.size());
      failures++;
    end
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Driver: present queued words, predict each one as it is accepted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      drv_show = in_if.valid;
      if (in_if.valid && in_if.ready) begin
        expected_results.push_back(uart_step(on_wire));
        n_issued++;
        drv_show = 1'b0;
        if (n_issued < calm_from && $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(1, 12);
        end
      end
      if (!drv_show) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_words.size() > 0 &&
                     !(pending_words[0].hold && n_issued != n_checked)) begin
          on_wire = pending_words.pop_front();
          in_if.cmd <= on_wire.cmd;
          in_if.byte_in <= on_wire.data;
          in_if.framing_flag <= on_wire.fe;
          in_if.overrun_flag <= on_wire.ov;
          in_if.parity_flag <= on_wire.pe;
          drv_show = 1'b1;
        end
      end
      in_if.valid <= drv_show;
    end
  end

  // Monitor: check each result word against the oldest prediction, stall at random.
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (expected_results.size() == 0) begin
          $error("result word arrived with nothing expected");
          failures++;
        end else begin
          want = expected_results.pop_front();
          compare_field("accepted", want.accepted, out_if.accepted);
          compare_field("byte_out", want.byte_out, out_if.byte_out);
          compare_field("last_error_code", want.last_error_code, out_if.last_error_code);
          compare_field("rx_ready", want.rx_ready, out_if.rx_ready);
          compare_field("tx_ready", want.tx_ready, out_if.tx_ready);
          compare_field("tx_irq_enable", want.tx_irq_enable, out_if.tx_irq_enable);
          compare_field("hw_error_total", want.hw_error_total, out_if.hw_error_total);
          compare_field("framing_total", want.framing_total, out_if.framing_total);
          compare_field("overflow_total", want.overflow_total, out_if.overflow_total);
          compare_field("parity_total", want.parity_total, out_if.parity_total);
          compare_field("rx_total", want.rx_total, out_if.rx_total);
          compare_field("tx_total", want.tx_total, out_if.tx_total);
        end
        n_checked <= n_checked + 1;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (n_checked < calm_from && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 11);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Hard limit on run length.
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
